### hw/rtl/ddwm_pkg.sv
// ----------------------------------------------------------------------------
// ddwm_pkg: shared types and constants of the distinct destination monitor
// Item layouts, opcodes, register indexes and reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package ddwm_pkg;

    localparam int SOURCE_SLOTS_DEFAULT = 2;
    localparam int DEST_SLOTS_DEFAULT   = 3;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;
    localparam int TICKS_W     = 32;
    localparam int ADDR_W      = 32;

    localparam logic [CFG_INDEX_W-1:0] CFG_REPORTING_ENABLED  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SHORT_WINDOW_TICKS = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_LONG_WINDOW_TICKS  = 2'd2;

    localparam logic [TICKS_W-1:0] SHORT_WINDOW_RESET = 32'd180;
    localparam logic [TICKS_W-1:0] LONG_WINDOW_RESET  = 32'd3600;

    localparam logic OP_REPORT = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    typedef struct packed {
        logic              opcode;
        logic [ADDR_W-1:0] source_address;
        logic [ADDR_W-1:0] dest_address;
        logic              from_watched_app;
    } t_in_item;

    typedef struct packed {
        logic slow_event;
        logic long_window_active;
    } t_out_item;

    typedef struct packed {
        logic                   we;
        logic [CFG_INDEX_W-1:0] index;
        logic [CFG_DATA_W-1:0]  data;
    } t_cfg_write;

endpackage

`default_nettype wire

### hw/rtl/distinct_destination_window_monitor.sv
// ----------------------------------------------------------------------------
// distinct_destination_window_monitor: top level
// Count distinct destinations per source over a short window and raise a
// slow event when a source reaches capacity; ticks run the window timer.
// ----------------------------------------------------------------------------
// Each transfer, report or tick, gives exactly one result. The block takes
// one item per clock cycle while the output flows; the result is registered
// behind the input register (the item sits in the input register while the
// table and timer update into the result register).
// While a result waits on a stalled output, one more item is taken into the
// input register and the input side then stalls until the result is taken.
// Register writes take effect at the clock edge of the write; a new window
// length is used the next time the timer is loaded.
`default_nettype none

module distinct_destination_window_monitor #(
    parameter int SOURCE_SLOTS = ddwm_pkg::SOURCE_SLOTS_DEFAULT,
    parameter int DEST_SLOTS   = ddwm_pkg::DEST_SLOTS_DEFAULT
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [ddwm_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  wire logic [ddwm_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_stall,
    input  wire ddwm_pkg::t_in_item                  i_in_data,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_stall,
    output ddwm_pkg::t_out_item                      o_out_data
);

    logic                 w_in_valid;
    ddwm_pkg::t_in_item   w_in_data;
    logic                 w_fire;
    ddwm_pkg::t_out_item  w_result;
    ddwm_pkg::t_cfg_write w_cfg;

    logic                 r_out_valid;
    ddwm_pkg::t_out_item  r_out_data;

    assign w_fire = w_in_valid && (!r_out_valid || !i_out_stall);

    assign w_cfg.we    = i_cfg_we;
    assign w_cfg.index = i_cfg_index;
    assign w_cfg.data  = i_cfg_data;

    ddwm_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_stall (o_in_stall),
        .i_data  (i_in_data),
        .i_take  (w_fire),
        .o_valid (w_in_valid),
        .o_data  (w_in_data)
    );

    ddwm_engine #(
        .SOURCE_SLOTS (SOURCE_SLOTS),
        .DEST_SLOTS   (DEST_SLOTS)
    ) u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (w_cfg),
        .i_fire   (w_fire),
        .i_item   (w_in_data),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_data <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

`default_nettype wire

### hw/rtl/ddwm_in_stage.sv
// ----------------------------------------------------------------------------
// ddwm_in_stage: input register
// Capture one input transfer and hold it until the engine takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module ddwm_in_stage (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire ddwm_pkg::t_in_item i_data,
    input  wire logic              i_take,
    output logic                   o_valid,
    output ddwm_pkg::t_in_item     o_data
);

    logic               r_valid;
    ddwm_pkg::t_in_item r_data;

    assign o_stall = r_valid && !i_take;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_data <= i_data;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/ddwm_engine.sv
// ----------------------------------------------------------------------------
// ddwm_engine: source table, destination lists and window timer
// Update the table and the window state for one item per cycle while items are fired in.
// ----------------------------------------------------------------------------
`default_nettype none

module ddwm_engine #(
    parameter int SOURCE_SLOTS = ddwm_pkg::SOURCE_SLOTS_DEFAULT,
    parameter int DEST_SLOTS   = ddwm_pkg::DEST_SLOTS_DEFAULT
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire ddwm_pkg::t_cfg_write   i_cfg,
    input  wire logic                   i_fire,
    input  wire ddwm_pkg::t_in_item     i_item,
    output ddwm_pkg::t_out_item         o_result
);

    localparam int CW = $clog2(DEST_SLOTS + 1);
    localparam logic [CW-1:0] FULL = CW'(DEST_SLOTS);

    logic                          r_enable;
    logic [ddwm_pkg::TICKS_W-1:0]  r_short_len;
    logic [ddwm_pkg::TICKS_W-1:0]  r_long_len;
    logic [ddwm_pkg::ADDR_W-1:0]   r_src   [SOURCE_SLOTS];
    logic [CW-1:0]                 r_count [SOURCE_SLOTS];
    logic [ddwm_pkg::ADDR_W-1:0]   r_dest  [SOURCE_SLOTS][DEST_SLOTS];
    logic                          r_long;
    logic [ddwm_pkg::TICKS_W-1:0]  r_countdown;

    logic                          n_long;
    logic [ddwm_pkg::TICKS_W-1:0]  n_countdown;
    logic                          n_clear;

    logic [SOURCE_SLOTS-1:0]       w_sel;
    logic [SOURCE_SLOTS-1:0]       w_found;
    logic [SOURCE_SLOTS-1:0]       w_record;
    logic [SOURCE_SLOTS-1:0]       w_hit_full;
    logic [SOURCE_SLOTS-1:0]       w_is_full;
    logic [CW-1:0]                 w_cnt_next [SOURCE_SLOTS];
    logic                          w_report;
    logic                          w_event;
    logic                          w_expire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable    <= 1'b0;
            r_short_len <= ddwm_pkg::SHORT_WINDOW_RESET;
            r_long_len  <= ddwm_pkg::LONG_WINDOW_RESET;
        end else if (i_cfg.we) begin
            case (i_cfg.index)
                ddwm_pkg::CFG_REPORTING_ENABLED:  r_enable    <= i_cfg.data[0];
                ddwm_pkg::CFG_SHORT_WINDOW_TICKS: r_short_len <= i_cfg.data;
                ddwm_pkg::CFG_LONG_WINDOW_TICKS:  r_long_len  <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // first slot that is empty or already holds this source
    always_comb begin
        logic v_taken;
        v_taken = 1'b0;
        for (int i = 0; i < SOURCE_SLOTS; i++) begin
            w_sel[i] = ((r_src[i] == '0) || (r_src[i] == i_item.source_address)) && !v_taken;
            v_taken  = v_taken || w_sel[i];
        end
    end

    always_comb begin
        for (int i = 0; i < SOURCE_SLOTS; i++) begin
            w_found[i] = 1'b0;
            for (int j = 0; j < DEST_SLOTS; j++) begin
                if ((CW'(j) < r_count[i]) && (r_dest[i][j] == i_item.dest_address)) begin
                    w_found[i] = 1'b1;
                end
            end
            w_record[i]   = w_sel[i] && (r_count[i] < FULL) && !w_found[i];
            w_cnt_next[i] = r_count[i] + CW'(w_record[i]);
            w_hit_full[i] = w_sel[i] && (w_cnt_next[i] == FULL);
            w_is_full[i]  = (r_count[i] == FULL);
        end
    end

    assign w_report = (i_item.opcode == ddwm_pkg::OP_REPORT) && r_enable
                      && i_item.from_watched_app && !r_long;
    assign w_event  = w_report && (|w_hit_full);
    assign w_expire = (i_item.opcode == ddwm_pkg::OP_TICK)
                      && (r_countdown <= ddwm_pkg::TICKS_W'(1));

    always_comb begin
        n_long      = r_long;
        n_countdown = r_countdown;
        n_clear     = 1'b0;
        if (i_item.opcode == ddwm_pkg::OP_TICK) begin
            if (!w_expire) begin
                n_countdown = r_countdown - ddwm_pkg::TICKS_W'(1);
            end else if (r_long || !(|w_is_full)) begin
                n_clear     = 1'b1;
                n_long      = 1'b0;
                n_countdown = r_short_len;
            end else begin
                n_long      = 1'b1;
                n_countdown = r_long_len;
            end
        end else if (w_event) begin
            n_long      = 1'b1;
            n_countdown = r_long_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_long      <= 1'b0;
            r_countdown <= ddwm_pkg::SHORT_WINDOW_RESET;
            for (int i = 0; i < SOURCE_SLOTS; i++) begin
                r_src[i]   <= '0;
                r_count[i] <= '0;
            end
        end else if (i_fire) begin
            r_long      <= n_long;
            r_countdown <= n_countdown;
            for (int i = 0; i < SOURCE_SLOTS; i++) begin
                if (n_clear) begin
                    r_src[i]   <= '0;
                    r_count[i] <= '0;
                end else if (w_report && w_sel[i]) begin
                    r_src[i]   <= i_item.source_address;
                    r_count[i] <= w_cnt_next[i];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < SOURCE_SLOTS; i++) begin
            for (int j = 0; j < DEST_SLOTS; j++) begin
                if (i_fire && w_report && w_record[i] && (r_count[i] == CW'(j))) begin
                    r_dest[i][j] <= i_item.dest_address;
                end
            end
        end
    end

    assign o_result.slow_event         = w_event;
    assign o_result.long_window_active = n_long;

    a_event_enters_long: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && w_event |=> r_long && (r_countdown == $past(r_long_len)))
        else $error("slow event did not enter the long window");

    a_event_only_on_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_event |-> (i_item.opcode == ddwm_pkg::OP_REPORT) && !r_long)
        else $error("slow event outside a short-window report");

    a_single_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_sel))
        else $error("more than one source slot selected");

    a_timer_idle_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_fire |=> $stable(r_countdown) && $stable(r_long))
        else $error("window state changed without a transfer");

    a_long_needs_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && !r_long && n_long |-> (|w_hit_full) || (|w_is_full))
        else $error("long window entered with no full slot");

endmodule

`default_nettype wire
